// ----- hw/rtl/frp_pkg.sv -----
// frp_pkg: shared types, codes and reset constants for the fifo page replacement block
// used by frp_addr_check, frp_page_table and fifo_page_replacement; no dependencies
package frp_pkg;

    localparam int FRP_PAGES      = 32;
    localparam int FRP_PAGE_SHIFT = 12;

    localparam int ADDR_W  = 32;
    localparam int PRIO_W  = 6;
    localparam int COUNT_W = 6;
    localparam int LIMIT_W = 6;
    localparam int PIDX_W  = 5;
    localparam int STAT_W  = 2;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'hf9f8_c000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd3;
    localparam logic [PRIO_W-1:0]  PRIO_MAX    = 6'd63;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RESIDENT = 2'd2;

    // configuration register indexes
    localparam logic CFG_REGION_BASE  = 1'b0;
    localparam logic CFG_MAX_RESIDENT = 1'b1;

    typedef struct packed {
        logic [PIDX_W-1:0] evict_page;
        logic              evict_valid;
        logic              first_touch;
        logic [PIDX_W-1:0] page_index;
        logic [STAT_W-1:0] status;
    } frp_result_t;

endpackage

// ----- hw/rtl/frp_addr_check.sv -----
// frp_addr_check: subtracts the region base, checks the region bounds, extracts the page number
// depends on frp_pkg
module frp_addr_check #(
    parameter int PAGES      = frp_pkg::FRP_PAGES,
    parameter int PAGE_SHIFT = frp_pkg::FRP_PAGE_SHIFT,
    parameter int PW         = $clog2(PAGES)
) (
    input  logic [frp_pkg::ADDR_W-1:0] fault_addr,
    input  logic [frp_pkg::ADDR_W-1:0] region_base,
    output logic                       out_of_range,
    output logic [PW-1:0]              page
);
    import frp_pkg::*;

    localparam logic [ADDR_W-1:0] SPAN = ADDR_W'(PAGES) << PAGE_SHIFT;

    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] offset;

    // top bit of the widened difference flags an address below the base
    assign diff         = {1'b0, fault_addr} - {1'b0, region_base};
    assign offset       = diff[ADDR_W-1:0];
    assign out_of_range = diff[ADDR_W] || (offset >= SPAN);
    assign page         = offset[PAGE_SHIFT +: PW];

endmodule

// ----- hw/rtl/frp_page_table.sv -----
// frp_page_table: per-page age priorities, touched flags, resident count and victim encoder
// depends on frp_pkg
module frp_page_table #(
    parameter int PAGES = frp_pkg::FRP_PAGES,
    parameter int PW    = $clog2(PAGES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd,
    input  logic                        req_oor,
    input  logic [PW-1:0]               req_page,
    input  logic [frp_pkg::LIMIT_W-1:0] max_resident,
    output frp_pkg::frp_result_t        res
);
    import frp_pkg::*;

    logic [PRIO_W-1:0]  prio_reg [PAGES];
    logic [PRIO_W-1:0]  prio_next [PAGES];
    logic [PRIO_W-1:0]  aged [PAGES];
    logic [PAGES-1:0]   touched_reg;
    logic [PAGES-1:0]   touched_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [PRIO_W-1:0]  new_prio;
    logic               evict_en;
    logic               found;
    logic [PW-1:0]      victim;
    logic               resident;

    assign resident  = (prio_reg[req_page] != '0);
    assign new_prio  = (max_resident == LIMIT_W'(PRIO_MAX)) ? PRIO_MAX
                                                           : PRIO_W'(max_resident + 1'b1);
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    assign evict_en  = (count_inc > COUNT_W'(max_resident));

    // aging pass over all pages, faulting page enters at the top
    always_comb
    begin
        for (int i = 0; i < PAGES; i++)
        begin
            if (PW'(i) == req_page)
                aged[i] = new_prio;
            else if (prio_reg[i] > PRIO_W'(1))
                aged[i] = prio_reg[i] - 1'b1;
            else
                aged[i] = prio_reg[i];
        end
    end

    // find-first victim at priority one, lowest page wins
    always_comb
    begin
        found  = 1'b0;
        victim = '0;
        for (int i = PAGES - 1; i >= 0; i--)
        begin
            if (evict_en && aged[i] == PRIO_W'(1))
            begin
                found  = 1'b1;
                victim = PW'(i);
            end
        end
    end

    always_comb
    begin
        res          = '0;
        prio_next    = prio_reg;
        touched_next = touched_reg;
        count_next   = count_reg;
        if (req_oor)
        begin
            res.status = STATUS_RANGE;
        end
        else if (resident)
        begin
            res.status     = STATUS_RESIDENT;
            res.page_index = PIDX_W'(req_page);
        end
        else
        begin
            res.status      = STATUS_OK;
            res.page_index  = PIDX_W'(req_page);
            res.first_touch = !touched_reg[req_page];
            res.evict_valid = found;
            res.evict_page  = PIDX_W'(victim);
            prio_next       = aged;
            if (found)
                prio_next[victim] = '0;
            touched_next[req_page] = 1'b1;
            count_next = found ? count_inc - 1'b1 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGES; i++)
                prio_reg[i] <= '0;
            touched_reg <= '0;
            count_reg   <= '0;
        end
        else if (upd)
        begin
            prio_reg    <= prio_next;
            touched_reg <= touched_next;
            count_reg   <= count_next;
        end
    end

    a_evict_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        upd && res.evict_valid |-> res.status == STATUS_OK)
        else $error("eviction reported on a rejected fault");

    a_touch_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        upd && res.status == STATUS_OK |=> touched_reg[$past(req_page)])
        else $error("faulted page not marked touched");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd || res.status != STATUS_OK |=> $stable(count_reg) && $stable(touched_reg))
        else $error("page state changed without an accepted fault");

    a_victim_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        upd && res.evict_valid && (victim != req_page) |=> prio_reg[$past(victim)] == '0)
        else $error("evicted page still resident");

endmodule

// ----- hw/rtl/fifo_page_replacement.sv -----
// fifo_page_replacement: top level, stream ports, configuration registers, input and result registers
// depends on frp_pkg, frp_addr_check and frp_page_table
//
// One page-fault address per item; the result reports the page, whether it needs a zero fill
// and the page evicted to stay within max_resident. The block takes one item per cycle when the
// result side keeps up; an accepted item sits in the input register and moves into the result
// register when the result slot is free, which then offers it on m_tvalid. The rate is set by
// the page table update: the aging of all priorities and the find-first victim encoder are
// combinational, so each item sees the state left by the one before it. Configuration writes
// take effect at the next clock edge.
module fifo_page_replacement #(
    parameter int PAGES      = frp_pkg::FRP_PAGES,
    parameter int PAGE_SHIFT = frp_pkg::FRP_PAGE_SHIFT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [frp_pkg::ADDR_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] fault_addr
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata    // [1:0] status, [6:2] page_index,
                                                   // [7] first_touch, [8] evict_valid,
                                                   // [13:9] evict_page, [15:14] zero
);
    import frp_pkg::*;

    localparam int PW = $clog2(PAGES);

    logic [ADDR_W-1:0]  region_base_reg;
    logic [LIMIT_W-1:0] max_resident_reg;
    logic               in_valid_reg;
    logic [ADDR_W-1:0]  in_addr_reg;
    logic               out_valid_reg;
    frp_result_t        out_reg;
    frp_result_t        res;
    logic               advance;
    logic               oor;
    logic [PW-1:0]      page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= BASE_RESET;
            max_resident_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_BASE:  region_base_reg  <= cfg_wdata;
                CFG_MAX_RESIDENT: max_resident_reg <= cfg_wdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // item moves from input register to result register when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_addr_reg <= s_tdata;
    end

    frp_addr_check #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .PW         (PW)
    ) u_addr_check (
        .fault_addr    (in_addr_reg),
        .region_base   (region_base_reg),
        .out_of_range  (oor),
        .page          (page)
    );

    frp_page_table #(
        .PAGES (PAGES),
        .PW    (PW)
    ) u_page_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (advance),
        .req_oor      (oor),
        .req_page     (page),
        .max_resident (max_resident_reg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule
